>>> design/q2e_pkg.sv
// ============================================================================
// q2e_pkg
// Shared widths, codes and the CORDIC arctangent table for the quaternion
// to Euler angle converter.
// ============================================================================
`default_nettype none

package q2e_pkg;

    // Field widths
    localparam int IN_W    = 16;
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 17;
    localparam int POLE_W  = 2;

    // Parameter defaults
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // CORDIC datapath
    localparam int TABLE_LEN   = 24;
    localparam int OP_W        = 42;   // operand after normalizing, |v| < 2^41
    localparam int CW          = 45;   // rotation datapath, room for the gain
    localparam int ZW          = 35;   // Q30 angle accumulator
    localparam int NORM_STAGES = 6;    // shifts by 32, 16, 8, 4, 2, 1

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

    // Pole codes
    localparam logic [POLE_W-1:0] POLE_NONE  = 2'd0;
    localparam logic [POLE_W-1:0] POLE_NORTH = 2'd1;
    localparam logic [POLE_W-1:0] POLE_SOUTH = 2'd2;

    // atan(2^-i) in Q30
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 35'sd843314857;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043837;
            5'd3:    v = 35'sd133525159;
            5'd4:    v = 35'sd67021687;
            5'd5:    v = 35'sd33543516;
            5'd6:    v = 35'sd16775851;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194283;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048576;
            5'd11:   v = 35'sd524288;
            5'd12:   v = 35'sd262144;
            5'd13:   v = 35'sd131072;
            5'd14:   v = 35'sd65536;
            5'd15:   v = 35'sd32768;
            5'd16:   v = 35'sd16384;
            5'd17:   v = 35'sd8192;
            5'd18:   v = 35'sd4096;
            5'd19:   v = 35'sd2048;
            5'd20:   v = 35'sd1024;
            5'd21:   v = 35'sd512;
            5'd22:   v = 35'sd256;
            5'd23:   v = 35'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/q2e_atan2.sv
// ============================================================================
// q2e_atan2
// Pipelined atan2(y, x): normalizing shift stages, quadrant pre-rotation and
// one vectoring CORDIC step per register stage.
// ============================================================================
`default_nettype none

module q2e_atan2 #(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire  signed [q2e_pkg::OP_W-1:0]  i_yv,
    input  wire  signed [q2e_pkg::OP_W-1:0]  i_xv,
    output logic signed [q2e_pkg::ZW-1:0]    o_angle
);

    localparam int OPW = q2e_pkg::OP_W;
    localparam int CW  = q2e_pkg::CW;
    localparam int ZW  = q2e_pkg::ZW;
    localparam int NS  = q2e_pkg::NORM_STAGES;
    localparam int N   = (STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN : STEPS;

    // Normalizing stages
    logic signed [OPW-1:0] r_nx [1:NS];
    logic signed [OPW-1:0] r_ny [1:NS];
    logic                  r_nzero [1:NS];

    // Rotation stages, index 0 is the pre-rotated operand
    logic signed [CW-1:0] r_cx [0:N];
    logic signed [CW-1:0] r_cy [0:N];
    logic signed [ZW-1:0] r_cz [0:N];
    logic                 r_czero [0:N];

    // Double both operands until one magnitude reaches 2^40, in binary steps
    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - s);
        localparam logic signed [OPW-1:0] LIM =
            {{(OPW-1){1'b0}}, 1'b1} << (OPW - 1 - SH);
        logic signed [OPW-1:0] sx, sy;
        logic                  sz, fits;
        if (s == 0) begin : g_first
            assign sx = i_xv;
            assign sy = i_yv;
            assign sz = (i_xv == '0) && (i_yv == '0);
        end else begin : g_next
            assign sx = r_nx[s];
            assign sy = r_ny[s];
            assign sz = r_nzero[s];
        end
        assign fits = (sx < LIM) && (sx > -LIM) && (sy < LIM) && (sy > -LIM);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[s+1]    <= fits ? (sx <<< SH) : sx;
                r_ny[s+1]    <= fits ? (sy <<< SH) : sy;
                r_nzero[s+1] <= sz;
            end
        end
    end

    // Move the left half plane into the right half by a quarter turn
    logic signed [CW-1:0] px, py;
    assign px = CW'(r_nx[NS]);
    assign py = CW'(r_ny[NS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czero[0] <= r_nzero[NS];
            if (px < 0) begin
                if (py >= 0) begin
                    r_cx[0] <= py;
                    r_cy[0] <= -px;
                    r_cz[0] <= q2e_pkg::HALF_PI_Q30;
                end else begin
                    r_cx[0] <= -py;
                    r_cy[0] <= px;
                    r_cz[0] <= -q2e_pkg::HALF_PI_Q30;
                end
            end else begin
                r_cx[0] <= px;
                r_cy[0] <= py;
                r_cz[0] <= '0;
            end
        end
    end

    // Vectoring steps, drive y toward zero
    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] ang;
        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign ang = q2e_pkg::atan_entry(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_czero[i+1] <= r_czero[i];
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + dx;
                    r_cy[i+1] <= r_cy[i] - dy;
                    r_cz[i+1] <= r_cz[i] + ang;
                end else begin
                    r_cx[i+1] <= r_cx[i] - dx;
                    r_cy[i+1] <= r_cy[i] + dy;
                    r_cz[i+1] <= r_cz[i] - ang;
                end
            end
        end
    end

    // Both operands zero give angle zero
    assign o_angle = r_czero[N] ? '0 : r_cz[N];

endmodule

`default_nettype wire

>>> design/quaternion_to_euler.sv
// ============================================================================
// quaternion_to_euler
// Quaternion (w, x, y, z) in Q1.14 to roll, pitch and yaw in radians, with
// north and south pole detection.
// ============================================================================
//
//  Channel  | Dir | tdata fields (low bit up)            | tuser
//  ---------+-----+--------------------------------------+-----------
//  s (in)   | in  | quat_w, quat_x, quat_y, quat_z       | -
//  m (out)  | out | roll_angle, pitch_angle, yaw_angle   | pole_case
//
//  One item enters per cycle unless stalled. Stages: input capture, products,
//  sums, sqrt factors, pole test; 32 stages of bit-serial square root;
//  normalizing, pre-rotation and vectoring in the three parallel CORDIC lanes;
//  one output stage. The whole pipe advances when the output register is
//  empty or taken; a stall freezes every stage. Reset clears only the valid bits.
//
`default_nettype none

module quaternion_to_euler #(
    parameter int CORDIC_STEPS    = q2e_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic [1:0]  o_m_tuser    // pole_case
);

    localparam int OPW   = q2e_pkg::OP_W;
    localparam int ZW    = q2e_pkg::ZW;
    localparam int NSTEP = (CORDIC_STEPS > q2e_pkg::TABLE_LEN) ?
                           q2e_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int LAT   = q2e_pkg::NORM_STAGES + 1 + NSTEP;
    localparam int SQ    = 32;
    localparam int SHR   = 30 - ANGLE_FRAC_BITS;
    localparam int RW    = ZW + 2;
    localparam logic signed [RW-1:0] RND = {{(RW-1){1'b0}}, 1'b1} << (SHR - 1);

    logic en;

    // Stage 1: input capture
    logic               r1_v;
    logic signed [15:0] r1_w, r1_x, r1_y, r1_z;
    // Stage 2: products
    logic               r2_v;
    logic signed [31:0] r2_ww, r2_xx, r2_yy, r2_zz, r2_xy, r2_zw;
    logic signed [31:0] r2_yw, r2_xz, r2_xw, r2_yz;
    logic signed [15:0] r2_w, r2_x;
    // Stage 3: sums
    logic               r3_v;
    logic signed [33:0] r3_unit, r3_yn, r3_yd, r3_rn, r3_rd;
    logic signed [32:0] r3_test;
    logic signed [15:0] r3_w, r3_x;
    // Stage 4: sqrt factors and pole scaling
    logic               r4_v;
    logic [31:0]        r4_d, r4_e;
    logic signed [42:0] r4_p1000, r4_p499;
    logic signed [33:0] r4_a, r4_yn, r4_yd, r4_rn, r4_rd;
    logic signed [15:0] r4_w, r4_x;

    // Square root pipe, index 0 is stage 5
    logic                  r_qv   [0:SQ];
    logic [63:0]           r_rem  [0:SQ];
    logic [63:0]           r_res  [0:SQ];
    logic [1:0]            r_qp   [0:SQ];
    logic signed [OPW-1:0] r_yawy [0:SQ];
    logic signed [OPW-1:0] r_yawx [0:SQ];
    logic signed [OPW-1:0] r_roly [0:SQ];
    logic signed [OPW-1:0] r_rolx [0:SQ];
    logic signed [OPW-1:0] r_pity [0:SQ];

    // Alignment with the CORDIC lanes
    logic       r_dv [1:LAT];
    logic [1:0] r_dp [1:LAT];

    // Output register
    logic                       r_out_vld;
    logic signed [15:0]         r_out_roll;
    logic signed [14:0]         r_out_pitch;
    logic signed [16:0]         r_out_yaw;
    logic [1:0]                 r_out_pole;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r_qv[0]   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_v      <= i_s_tvalid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r_qv[0]   <= r4_v;
            r_out_vld <= r_dv[LAT];
        end
    end

    // Stages 1 to 4
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w <= i_s_tdata[15:0];
            r1_x <= i_s_tdata[31:16];
            r1_y <= i_s_tdata[47:32];
            r1_z <= i_s_tdata[63:48];

            r2_ww <= 32'(r1_w) * 32'(r1_w);
            r2_xx <= 32'(r1_x) * 32'(r1_x);
            r2_yy <= 32'(r1_y) * 32'(r1_y);
            r2_zz <= 32'(r1_z) * 32'(r1_z);
            r2_xy <= 32'(r1_x) * 32'(r1_y);
            r2_zw <= 32'(r1_z) * 32'(r1_w);
            r2_yw <= 32'(r1_y) * 32'(r1_w);
            r2_xz <= 32'(r1_x) * 32'(r1_z);
            r2_xw <= 32'(r1_x) * 32'(r1_w);
            r2_yz <= 32'(r1_y) * 32'(r1_z);
            r2_w  <= r1_w;
            r2_x  <= r1_x;

            r3_unit <= 34'(r2_ww) + 34'(r2_xx) + 34'(r2_yy) + 34'(r2_zz);
            r3_test <= 33'(r2_xy) + 33'(r2_zw);
            r3_yn   <= (34'(r2_yw) - 34'(r2_xz)) <<< 1;
            r3_yd   <= 34'(r2_xx) - 34'(r2_yy) - 34'(r2_zz) + 34'(r2_ww);
            r3_rn   <= (34'(r2_xw) - 34'(r2_yz)) <<< 1;
            r3_rd   <= 34'(r2_yy) - 34'(r2_xx) - 34'(r2_zz) + 34'(r2_ww);
            r3_w    <= r2_w;
            r3_x    <= r2_x;

            r4_d     <= 32'((35'(r3_unit) - (35'(r3_test) <<< 1)) >>> 2);
            r4_e     <= 32'((35'(r3_unit) + (35'(r3_test) <<< 1)) >>> 2);
            r4_p1000 <= 43'(r3_test) * 43'sd1000;
            r4_p499  <= 43'(r3_unit) * 43'sd499;
            r4_a     <= 34'(r3_test) <<< 1;
            r4_yn    <= r3_yn;
            r4_yd    <= r3_yd;
            r4_rn    <= r3_rn;
            r4_rd    <= r3_rd;
            r4_w     <= r3_w;
            r4_x     <= r3_x;
        end
    end

    // Stage 5: pole test, radicand product, lane operand select
    logic [1:0] pole5;
    always_comb begin
        if (r4_p1000 > r4_p499) begin
            pole5 = q2e_pkg::POLE_NORTH;
        end else if (r4_p1000 < -r4_p499) begin
            pole5 = q2e_pkg::POLE_SOUTH;
        end else begin
            pole5 = q2e_pkg::POLE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0]  <= 64'(r4_d) * 64'(r4_e);
            r_res[0]  <= '0;
            r_qp[0]   <= pole5;
            r_yawy[0] <= (pole5 != q2e_pkg::POLE_NONE) ? OPW'(r4_x) : OPW'(r4_yn);
            r_yawx[0] <= (pole5 != q2e_pkg::POLE_NONE) ? OPW'(r4_w) : OPW'(r4_yd);
            r_roly[0] <= OPW'(r4_rn);
            r_rolx[0] <= OPW'(r4_rd);
            r_pity[0] <= OPW'(r4_a);
        end
    end

    // Integer square root, one result bit per stage
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = r_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k+1] <= 1'b0;
            end else if (en) begin
                r_qv[k+1] <= r_qv[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k+1] <= r_rem[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + BIT;
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
                r_qp[k+1]   <= r_qp[k];
                r_yawy[k+1] <= r_yawy[k];
                r_yawx[k+1] <= r_yawx[k];
                r_roly[k+1] <= r_roly[k];
                r_rolx[k+1] <= r_rolx[k];
                r_pity[k+1] <= r_pity[k];
            end
        end
    end

    // CORDIC lanes
    logic signed [OPW-1:0] pitch_x;
    logic signed [ZW-1:0]  yaw_z, roll_z, pitch_z;

    assign pitch_x = $signed({{(OPW-35){1'b0}}, r_res[SQ][32:0], 2'b00});

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_yv    (r_yawy[SQ]),
        .i_xv    (r_yawx[SQ]),
        .o_angle (yaw_z)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_yv    (r_roly[SQ]),
        .i_xv    (r_rolx[SQ]),
        .o_angle (roll_z)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_yv    (r_pity[SQ]),
        .i_xv    (pitch_x),
        .o_angle (pitch_z)
    );

    // Valid and pole code ride alongside the lanes
    for (genvar j = 1; j <= LAT; j++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (en) begin
                r_dv[j] <= (j == 1) ? r_qv[SQ] : r_dv[(j == 1) ? 1 : j - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dp[j] <= (j == 1) ? r_qp[SQ] : r_dp[(j == 1) ? 1 : j - 1];
            end
        end
    end

    // Pole overrides and rounding to the output grid
    logic signed [RW-1:0] yaw_q, pitch_q, roll_q;
    logic signed [RW-1:0] yaw_r, pitch_r, roll_r;
    logic [1:0]           pole_o;

    assign pole_o = r_dp[LAT];

    always_comb begin
        case (pole_o)
            q2e_pkg::POLE_NORTH: begin
                yaw_q   = RW'(yaw_z) <<< 1;
                pitch_q = RW'(q2e_pkg::HALF_PI_Q30);
            end
            q2e_pkg::POLE_SOUTH: begin
                yaw_q   = -(RW'(yaw_z) <<< 1);
                pitch_q = -RW'(q2e_pkg::HALF_PI_Q30);
            end
            default: begin
                yaw_q   = RW'(yaw_z);
                pitch_q = RW'(pitch_z);
            end
        endcase
        roll_q  = RW'(roll_z);
        yaw_r   = (yaw_q + RND) >>> SHR;
        pitch_r = (pitch_q + RND) >>> SHR;
        roll_r  = (roll_q + RND) >>> SHR;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_yaw   <= yaw_r[q2e_pkg::YAW_W-1:0];
            r_out_pitch <= pitch_r[q2e_pkg::PITCH_W-1:0];
            r_out_roll  <= (pole_o != q2e_pkg::POLE_NONE) ? '0 :
                           roll_r[q2e_pkg::ROLL_W-1:0];
            r_out_pole  <= pole_o;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_yaw, r_out_pitch, r_out_roll};
    assign o_m_tuser  = r_out_pole;

endmodule

`default_nettype wire

>>> design/q2e_checker.sv
// ============================================================================
// q2e_checker
// Port-level checks for quaternion_to_euler, attached by bind.
// ============================================================================
`default_nettype none

module q2e_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [47:0] o_m_tdata,
    input wire [1:0]  o_m_tuser
);

    // No item straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("item valid right after reset");

    // Pole code is one of the three defined codes
    a_pole_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == q2e_pkg::POLE_NONE) ||
                        (o_m_tuser == q2e_pkg::POLE_NORTH) ||
                        (o_m_tuser == q2e_pkg::POLE_SOUTH)))
        else $error("undefined pole code");

    // Roll is zero at either pole
    a_pole_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != q2e_pkg::POLE_NONE)) |-> (o_m_tdata[15:0] == 16'd0))
        else $error("nonzero roll at a pole");

    // A stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled item changed");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
